>>> rtl/sobel_pkg.sv
// shared types, constants and functions of the sobel edge block
package sobel_pkg;
  localparam int MaxScan = 1024;
  localparam int PosW = $clog2(MaxScan);
  localparam int LenW = 11;
  localparam int PixW = 8;
  localparam int MagW = 8;
  localparam int DirW = 9;
  localparam int GW = 12;
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);
  localparam logic [LenW-1:0] LenReset = LenW'(640);

  typedef struct packed {
    logic signed [GW-1:0] gx;
    logic signed [GW-1:0] gy;
  } grad_t;

  typedef struct packed {
    logic [MagW-1:0] magnitude;
    logic [DirW-1:0] direction;
  } res_t;

  // tan(k degrees) in unsigned q16, rounded
  function automatic logic [21:0] tan_q16(input logic [6:0] k);
    logic [21:0] t;
    unique case (k)
      7'd0: t = 22'd0; 7'd1: t = 22'd1144; 7'd2: t = 22'd2289; 7'd3: t = 22'd3435;
      7'd4: t = 22'd4583; 7'd5: t = 22'd5734; 7'd6: t = 22'd6888; 7'd7: t = 22'd8047;
      7'd8: t = 22'd9210; 7'd9: t = 22'd10380; 7'd10: t = 22'd11556;
      7'd11: t = 22'd12739; 7'd12: t = 22'd13930; 7'd13: t = 22'd15130;
      7'd14: t = 22'd16340; 7'd15: t = 22'd17560; 7'd16: t = 22'd18792;
      7'd17: t = 22'd20036; 7'd18: t = 22'd21294; 7'd19: t = 22'd22566;
      7'd20: t = 22'd23853; 7'd21: t = 22'd25157; 7'd22: t = 22'd26478;
      7'd23: t = 22'd27818; 7'd24: t = 22'd29179; 7'd25: t = 22'd30560;
      7'd26: t = 22'd31964; 7'd27: t = 22'd33392; 7'd28: t = 22'd34846;
      7'd29: t = 22'd36327; 7'd30: t = 22'd37837; 7'd31: t = 22'd39378;
      7'd32: t = 22'd40951; 7'd33: t = 22'd42560; 7'd34: t = 22'd44205;
      7'd35: t = 22'd45889; 7'd36: t = 22'd47615; 7'd37: t = 22'd49385;
      7'd38: t = 22'd51202; 7'd39: t = 22'd53070; 7'd40: t = 22'd54991;
      7'd41: t = 22'd56970; 7'd42: t = 22'd59009; 7'd43: t = 22'd61113;
      7'd44: t = 22'd63287; 7'd45: t = 22'd65536; 7'd46: t = 22'd67865;
      7'd47: t = 22'd70279; 7'd48: t = 22'd72785; 7'd49: t = 22'd75391;
      7'd50: t = 22'd78103; 7'd51: t = 22'd80930; 7'd52: t = 22'd83882;
      7'd53: t = 22'd86969; 7'd54: t = 22'd90203; 7'd55: t = 22'd93595;
      7'd56: t = 22'd97161; 7'd57: t = 22'd100917; 7'd58: t = 22'd104880;
      7'd59: t = 22'd109070; 7'd60: t = 22'd113512; 7'd61: t = 22'd118230;
      7'd62: t = 22'd123255; 7'd63: t = 22'd128622; 7'd64: t = 22'd134369;
      7'd65: t = 22'd140542; 7'd66: t = 22'd147196; 7'd67: t = 22'd154393;
      7'd68: t = 22'd162207; 7'd69: t = 22'd170727; 7'd70: t = 22'd180059;
      7'd71: t = 22'd190330; 7'd72: t = 22'd201699; 7'd73: t = 22'd214359;
      7'd74: t = 22'd228551; 7'd75: t = 22'd244584; 7'd76: t = 22'd262851;
      7'd77: t = 22'd283868; 7'd78: t = 22'd308323; 7'd79: t = 22'd337153;
      7'd80: t = 22'd371673; 7'd81: t = 22'd413778; 7'd82: t = 22'd466313;
      7'd83: t = 22'd533748; 7'd84: t = 22'd623533; 7'd85: t = 22'd749080;
      7'd86: t = 22'd937208; 7'd87: t = 22'd1250501; 7'd88: t = 22'd1876705;
      7'd89: t = 22'd3754555;
      default: t = 22'h3FFFFF;
    endcase
    return t;
  endfunction
endpackage

>>> rtl/sobel_if.sv
// valid/ready stream interfaces of the sobel edge block
interface sobel_pix_if;
  logic valid;
  logic ready;
  logic [7:0] pixel;
  logic frame_start;
  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface sobel_res_if;
  logic valid;
  logic ready;
  logic [7:0] magnitude;
  logic [8:0] direction;
  modport source (output valid, output magnitude, output direction, input ready);
  modport sink (input valid, input magnitude, input direction, output ready);
endinterface

>>> rtl/sobel_edge_magnitude_direction.sv
// top level of the sobel edge magnitude and direction block
// pixels enter on pix, scan by scan; results leave on res, one per interior pixel.
// scan_length is written through cfg_we/cfg_data and restarts the image;
// the user must write it only while idle, which the block does not enforce.
// the front end takes one pixel a cycle while the gradient queue is empty;
// the back end takes one gradient at a time and waits for the 89-step tan table
// search when the magnitude is below 90; the linear root search runs beside it
// and lasts longer for larger magnitudes. gradients may also wait in the queue.
// reset clears counters, window and queue; line stores stay undefined.
// when the receiver stalls the result holds, the queue stops draining and pix
// stalls while the queue holds any gradient.
module sobel_edge_magnitude_direction (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [10:0] cfg_data,
  sobel_pix_if.sink pix,
  sobel_res_if.source res
);
  import sobel_pkg::*;
  logic g_valid, room, qv, qrd;
  grad_t g, qd;
  res_t rd;
  sobel_front u_front (.clk, .rst, .cfg_we, .cfg_len(cfg_data), .in_valid(pix.valid),
    .in_ready(pix.ready), .in_pixel(pix.pixel), .in_fs(pix.frame_start),
    .g_valid, .g_data(g), .q_room(room));
  sobel_queue u_queue (.clk, .rst, .wr(g_valid), .wdata(g), .room, .rvalid(qv),
    .rd(qrd), .rdata(qd));
  sobel_back u_back (.clk, .rst, .q_valid(qv), .q_rd(qrd), .q_data(qd),
    .out_valid(res.valid), .out_ready(res.ready), .out_data(rd));
  assign res.magnitude = rd.magnitude;
  assign res.direction = rd.direction;
endmodule

>>> rtl/sobel_front.sv
// front end: line stores, 3x3 window and sobel gradients
module sobel_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [sobel_pkg::LenW-1:0]  cfg_len,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sobel_pkg::PixW-1:0]  in_pixel,
  input  logic                        in_fs,
  output logic                        g_valid,
  output sobel_pkg::grad_t            g_data,
  input  logic                        q_room
);
  import sobel_pkg::*;

  logic [PosW:0] len;
  logic [PosW:0] pos, pos_eff, pos_inc;
  logic [1:0] scans, scans_eff;
  logic [PixW-1:0] store_a [MaxScan];
  logic [PixW-1:0] store_b [MaxScan];
  logic [PixW-1:0] win [9];
  logic [PixW-1:0] old1, old2, pix_d;
  logic rd_valid, rd_emit;
  logic [PosW-1:0] rd_pos;
  logic signed [GW-1:0] gx, gy;

  // effective scan length, clamped
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= (PosW+1)'(LenReset);
    end else if (cfg_we) begin
      if (cfg_len < LenW'(3)) len <= (PosW+1)'(3);
      else if (cfg_len > LenW'(MaxScan)) len <= (PosW+1)'(MaxScan);
      else len <= (PosW+1)'(cfg_len);
    end
  end

  // stall while the gradient queue holds any entry
  assign in_ready = q_room;
  wire xfer = in_valid && in_ready;

  always_comb begin
    pos_eff = (in_fs || pos >= len) ? '0 : pos;
    scans_eff = in_fs ? 2'd0 : scans;
    pos_inc = pos_eff + 1'b1;
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      pos <= '0;
      scans <= '0;
    end else if (xfer) begin
      if (pos_inc >= len) begin
        pos <= '0;
        if (scans_eff < 2'd2) scans <= scans_eff + 2'd1;
        else scans <= scans_eff;
      end else begin
        pos <= pos_inc;
        scans <= scans_eff;
      end
    end
  end

  // line store read stage, write back on transfer
  always_ff @(posedge clk) begin
    if (xfer) begin
      old1 <= store_a[pos_eff[PosW-1:0]];
      old2 <= store_b[pos_eff[PosW-1:0]];
      store_a[pos_eff[PosW-1:0]] <= in_pixel;
    end
    // older scan takes the registered previous-scan entry in the following cycle
    if (rd_valid) store_b[rd_pos] <= old1;
    pix_d <= in_pixel;
    rd_pos <= pos_eff[PosW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      rd_emit <= 1'b0;
    end else begin
      rd_valid <= xfer;
      rd_emit <= xfer && scans_eff >= 2'd2 && pos_eff >= (PosW+1)'(2);
    end
  end

  // window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else if (rd_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3] <= win[r*3+1];
        win[r*3+1] <= win[r*3+2];
      end
      win[2] <= old2;
      win[5] <= old1;
      win[8] <= pix_d;
    end
  end

  // gradient of the window after the shift
  logic emit_d;
  always_ff @(posedge clk) begin
    if (rst) emit_d <= 1'b0;
    else emit_d <= rd_emit;
  end
  function automatic logic signed [GW-1:0] ext(input logic [PixW-1:0] v);
    return GW'($signed({1'b0, v}));
  endfunction
  always_comb begin
    gx = (ext(win[6]) - ext(win[0])) + ((ext(win[7]) - ext(win[1])) <<< 1)
       + (ext(win[8]) - ext(win[2]));
    gy = (ext(win[2]) - ext(win[0])) + ((ext(win[5]) - ext(win[3])) <<< 1)
       + (ext(win[8]) - ext(win[6]));
  end
  assign g_valid = emit_d;
  assign g_data.gx = gx;
  assign g_data.gy = gy;
endmodule

>>> rtl/sobel_queue.sv
// short fifo of gradients between front and back end
module sobel_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  sobel_pkg::grad_t wdata,
  output logic             room,
  output logic             rvalid,
  input  logic             rd,
  output sobel_pkg::grad_t rdata
);
  import sobel_pkg::*;
  grad_t mem [QDepth];
  logic [QPtrW:0] wp, rp, cnt;
  assign cnt = wp - rp;
  // room for the three items that can be in the front pipeline
  assign room = cnt == '0;
  assign rvalid = cnt != '0;
  assign rdata = mem[rp[QPtrW-1:0]];
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd && rvalid) rp <= rp + 1'b1;
    end
    if (wr) mem[wp[QPtrW-1:0]] <= wdata;
  end
endmodule

>>> rtl/sobel_back.sv
// back end: iterative square root and angle search
module sobel_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_rd,
  input  sobel_pkg::grad_t q_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sobel_pkg::res_t  out_data
);
  import sobel_pkg::*;
  localparam logic [1:0] SIdle = 2'd0, SRun = 2'd1, SDone = 2'd2;
  logic [1:0] state;
  logic [GW-1:0] ax, ay;
  logic sx, sy;
  logic [6:0] k, d;
  logic [8:0] r;
  logic [21:0] s;
  logic [37:0] lhs, rhs;
  logic [17:0] rr;

  assign q_rd = (state == SIdle) && q_valid;
  assign lhs = 38'(tan_q16(k)) * 38'(ay);
  assign rhs = {10'd0, ax, 16'd0};
  assign rr = 18'(r + 9'd1) * 18'(r + 9'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      out_valid <= 1'b0;
    end else begin
      // result register: load when done, clear once taken
      if (state == SDone && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        SIdle: if (q_valid) begin
          state <= SRun;
          sx <= q_data.gx[GW-1];
          sy <= q_data.gy[GW-1];
          ax <= q_data.gx[GW-1] ? -q_data.gx : q_data.gx;
          ay <= q_data.gy[GW-1] ? -q_data.gy : q_data.gy;
          s <= 22'(q_data.gx) * 22'(q_data.gx) + 22'(q_data.gy) * 22'(q_data.gy);
          k <= 7'd1;
          d <= 7'd0;
          r <= '0;
        end
        SRun: begin
          // one tan step and one root step per cycle
          if (k < 7'd90) begin
            if (lhs <= rhs) d <= k;
            k <= k + 7'd1;
          end
          if (r < 9'd256 && 22'(rr) <= s) r <= r + 9'd1;
          if (k >= 7'd90 && !(r < 9'd256 && 22'(rr) <= s)) state <= SDone;
        end
        SDone: if (!out_valid || out_ready) begin
          out_data.magnitude <= (s >= 22'd65025) ? 8'd255 : r[7:0];
          if (ay == '0) out_data.direction <= 9'd90;
          else if (d != 7'd0 && sx != sy) out_data.direction <= 9'd360 - 9'(d);
          else out_data.direction <= 9'(d);
          state <= SIdle;
        end
        default: state <= SIdle;
      endcase
    end
  end
endmodule

>>> rtl/sobel_checker.sv
// port-level checks of the sobel edge block
module sobel_checker (
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_ready,
  input logic [8:0] direction,
  input logic [7:0] magnitude
);
  a_dir: assert property (@(posedge clk) disable iff (rst) res_valid |-> direction < 9'd360)
    else $error("direction out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(magnitude))
    else $error("result dropped");
  a_rst: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("valid after reset");
endmodule

bind sobel_edge_magnitude_direction sobel_checker u_chk (.clk, .rst,
  .res_valid(res.valid), .res_ready(res.ready), .direction(res.direction),
  .magnitude(res.magnitude));

>>> tb/sobel_checker.sv
// scoreboard of the sobel edge block: watches the channels, predicts and compares results
module sobel_scoreboard
  import sobel_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [LenW-1:0] cfg_data,
  sobel_pix_if pix,
  sobel_res_if res,
  output int errors,
  output int pending,
  output int results_seen
);
  // tan(k degrees) in unsigned q16
  localparam int unsigned TanTab [90] = '{
    0, 1144, 2289, 3435, 4583, 5734, 6888, 8047, 9210, 10380,
    11556, 12739, 13930, 15130, 16340, 17560, 18792, 20036, 21294, 22566,
    23853, 25157, 26478, 27818, 29179, 30560, 31964, 33392, 34846, 36327,
    37837, 39378, 40951, 42560, 44205, 45889, 47615, 49385, 51202, 53070,
    54991, 56970, 59009, 61113, 63287, 65536, 67865, 70279, 72785, 75391,
    78103, 80930, 83882, 86969, 90203, 93595, 97161, 100917, 104880, 109070,
    113512, 118230, 123255, 128622, 134369, 140542, 147196, 154393, 162207, 170727,
    180059, 190330, 201699, 214359, 228551, 244584, 262851, 283868, 308323, 337153,
    371673, 413778, 466313, 533748, 623533, 749080, 937208, 1250501, 1876705, 3754555
  };

  logic [PixW-1:0] prev_scan [MaxScan];
  logic [PixW-1:0] older_scan [MaxScan];
  logic [PixW-1:0] win [9];
  int unsigned pos;
  int unsigned scans_done;
  logic [LenW-1:0] len_reg;
  res_t expected_q [$];

  assign pending = expected_q.size();

  function automatic int unsigned root_sat(int gx, int gy);
    int unsigned s;
    int unsigned r;
    s = gx * gx + gy * gy;
    r = 0;
    if (s >= 65025) return 255;
    while ((r + 1) * (r + 1) <= s) r++;
    return r;
  endfunction

  function automatic int unsigned angle_deg(int gx, int gy);
    longint unsigned ax, ay;
    int unsigned d;
    if (gy == 0) return 90;
    ax = (gx < 0) ? -gx : gx;
    ay = (gy < 0) ? -gy : gy;
    d = 0;
    for (int k = 1; k < 90; k++)
      if (longint'(TanTab[k]) * ay <= ax * 65536) d = k;
    if (d > 0 && ((gx < 0) != (gy < 0))) return 360 - d;
    return d;
  endfunction

  // one pixel transfer through the window and scan stores
  task automatic take_pixel(logic [PixW-1:0] p, logic fs);
    int unsigned n;
    logic [PixW-1:0] o1, o2;
    int gx, gy;
    res_t e;
    n = len_reg;
    if (n < 3) n = 3;
    if (n > MaxScan) n = MaxScan;
    if (fs) begin
      pos = 0;
      scans_done = 0;
    end
    if (pos >= n) pos = 0;
    o1 = prev_scan[pos];
    o2 = older_scan[pos];
    for (int r = 0; r < 3; r++) begin
      win[r*3] = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = o2;
    win[5] = o1;
    win[8] = p;
    if (scans_done >= 2 && pos >= 2) begin
      gx = (int'(win[6]) - int'(win[0])) + 2 * (int'(win[7]) - int'(win[1]))
         + (int'(win[8]) - int'(win[2]));
      gy = (int'(win[2]) - int'(win[0])) + 2 * (int'(win[5]) - int'(win[3]))
         + (int'(win[8]) - int'(win[6]));
      e.magnitude = MagW'(root_sat(gx, gy));
      e.direction = DirW'(angle_deg(gx, gy));
      expected_q = {expected_q, e};
    end
    older_scan[pos] = o1;
    prev_scan[pos] = p;
    pos++;
    if (pos >= n) begin
      pos = 0;
      if (scans_done < 2) scans_done++;
    end
  endtask

  initial begin
    errors = 0;
    results_seen = 0;
    for (int i = 0; i < MaxScan; i++) begin
      prev_scan[i] = '0;
      older_scan[i] = '0;
    end
  end

  // monitor all transfers at the clock edge
  always @(posedge clk) begin
    res_t got, e;
    if (rst) begin
      for (int i = 0; i < 9; i++) win[i] = '0;
      pos = 0;
      scans_done = 0;
      len_reg = LenReset;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        len_reg = cfg_data;
        pos = 0;
        scans_done = 0;
      end
      if (pix.valid && pix.ready) take_pixel(pix.pixel, pix.frame_start);
      if (res.valid && res.ready) begin
        got.magnitude = res.magnitude;
        got.direction = res.direction;
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("unexpected result magnitude %0d direction %0d",
                 got.magnitude, got.direction);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (got.magnitude !== e.magnitude) begin
            $error("magnitude expected %0d actual %0d", e.magnitude, got.magnitude);
            errors++;
          end
          if (got.direction !== e.direction) begin
            $error("direction expected %0d actual %0d", e.direction, got.direction);
            errors++;
          end
        end
      end
    end
  end
endmodule

>>> tb/tb.sv
// stimulus and verdict for the sobel edge magnitude and direction block
module tb;
  import sobel_pkg::*;

  localparam int CycleLimit = 3_000_000;
  localparam int DrainWait = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [LenW-1:0] cfg_data = '0;
  int idle_pct = 10;
  int errors, pending, results_seen;
  int pixels_sent = 0;
  int cfg_writes = 0;
  int cycles = 0;

  sobel_pix_if pix ();
  sobel_res_if res ();

  sobel_edge_magnitude_direction u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data), .pix(pix), .res(res)
  );

  sobel_scoreboard u_chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data), .pix(pix), .res(res),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  always #5 clk = ~clk;

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // receiver with random stalls
  initial begin
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      res.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // one pixel transfer with an optional random gap before it
  task automatic send(logic [7:0] p, logic fs);
    if ($urandom_range(99) < idle_pct) begin
      pix.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    pix.valid <= 1'b1;
    pix.pixel <= p;
    pix.frame_start <= fs;
    do @(posedge clk); while (!pix.ready);
    pixels_sent++;
  endtask

  // register write once the block has drained
  task automatic set_length(logic [LenW-1:0] v);
    pix.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // one image of a few scans, sometimes cut or restarted midway
  task automatic send_image(int len, int scans, bit lead_fs);
    int total;
    total = len * scans;
    if ($urandom_range(9) == 0) total = $urandom_range(1, total);
    for (int i = 0; i < total; i++) begin
      if ($urandom_range(19) == 0 && i > 0) send(rand_pixel(), 1'b1);
      else send(rand_pixel(), (i == 0) && lead_fs);
    end
  endtask

  initial begin
    int len;
    int stretch;
    pix.valid = 1'b0;
    pix.pixel = '0;
    pix.frame_start = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: length below range acts as three
    set_length('0);
    for (int i = 0; i < 9; i++) send(8'd0, i == 0);
    for (int i = 0; i < 9; i++) send((i >= 6) ? 8'd255 : 8'd0, i == 0);
    for (int i = 0; i < 9; i++) send((i % 3 == 2) ? 8'd255 : 8'd0, i == 0);
    // restart in mid-image, then opposite-sign gradients
    send(8'd77, 1'b1);
    send(8'd12, 1'b0);
    send(8'd255, 1'b1);
    send(8'd0, 1'b0);
    send(8'd0, 1'b0);
    send(8'd255, 1'b0);
    send(8'd0, 1'b0);
    send(8'd0, 1'b0);
    send(8'd0, 1'b0);
    send(8'd0, 1'b0);
    send(8'd255, 1'b0);

    // random images with short scans
    stretch = 0;
    while (pixels_sent < 350) begin
      len = $urandom_range(3, 10);
      set_length(LenW'(len));
      idle_pct = (stretch == 1) ? 0 : 10;
      stretch++;
      for (int k = 0; k < 4; k++) send_image(len, $urandom_range(3, 5), k != 0 ||
                                             $urandom_range(1) == 1);
    end
    idle_pct = 10;

    // widest scans: above range acts as the maximum, then the maximum itself
    set_length(LenW'(2047));
    for (int i = 0; i < 150; i++) send(rand_pixel(), i == 0);
    set_length(LenW'(MaxScan));
    for (int i = 0; i < 150; i++) send(rand_pixel(), i == 0);

    // drain and watch for strays
    pix.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("tb: %0d pixels, %0d results checked, %0d length writes",
             pixels_sent, results_seen, cfg_writes);
    $display("tb: scan lengths from the minimum to the maximum, with stalls on both sides");
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
